[rtl/assert_macros.svh]
// Assertion macros of the RTL of the radio receive packet queue.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RRPQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication.
`define RRPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

[rtl/rrpq_pkg.sv]
// Shared types, constants and helpers of the radio receive packet queue.
// No dependencies.
`timescale 1ns / 1ps

package rrpq_pkg;

    localparam int BUF_BYTES_DEF = 2048;
    localparam int PKT_OVERHEAD  = 6;
    localparam int SLOT_DEPTH    = 256;
    localparam int OFF_W         = 9;
    localparam int TDATA_W       = 56;

    localparam logic [7:0] PAYLOAD_LIMIT   = 8'd251;
    localparam logic [7:0] DEF_MAX_PAYLOAD = 8'd32;
    localparam logic [7:0] DEF_QUEUE_SLOTS = 8'd3;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_BYTE  = 2'd1,
        MODE_END   = 2'd2,
        MODE_READ  = 2'd3
    } mode_t;

    typedef enum logic {
        CFG_MAX_PAYLOAD = 1'b0,
        CFG_QUEUE_SLOTS = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        mode_t       mode;
        logic [7:0]  declared_len;
        logic [7:0]  data_byte;
        logic        crc_ok;
        logic [6:0]  rssi_sample;
        logic [31:0] timestamp;
    } rx_item_t;

    typedef struct packed {
        logic              queue_empty;
        logic [7:0]        payload_byte;
        logic [7:0]        packet_len;
        logic signed [7:0] rssi_dbm;
        logic [31:0]       rx_time;
        logic              last_byte;
    } rx_result_t;

    function automatic logic [7:0] clamp_len(input logic [7:0] v, input logic [7:0] lim);
        return (v > lim) ? lim : v;
    endfunction

endpackage

[rtl/rrpq_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module rrpq_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

[rtl/rrpq_ctrl.sv]
// Queue sequencer: receive slot fill, commit copy into the packet store, and
// the multi-read fetch of one result. Uses rrpq_pkg; drives the ports of two rrpq_ram instances.
`timescale 1ns / 1ps

module rrpq_ctrl #(
    parameter int BUF_BYTES = rrpq_pkg::BUF_BYTES_DEF,
    localparam int AW = $clog2(BUF_BYTES),
    localparam int UW = $clog2(BUF_BYTES + 1),
    localparam int SW = UW + 9
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rrpq_pkg::rx_item_t   s_item,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           eff_max,
    input  logic [SW-1:0]        capacity,
    output rrpq_pkg::rx_result_t m_result,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 st_we,
    output logic [AW-1:0]        st_waddr,
    output logic [7:0]           st_wdata,
    output logic [AW-1:0]        st_raddr,
    input  logic [7:0]           st_rdata,
    output logic                 sl_we,
    output logic [7:0]           sl_waddr,
    output logic [7:0]           sl_wdata,
    output logic [7:0]           sl_raddr,
    input  logic [7:0]           sl_rdata
);

    import rrpq_pkg::*;

    localparam int SUMW = ((AW > OFF_W) ? AW : OFF_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_CHK, S_COPY, S_TRAIL, S_RLEN, S_RBYTE, S_RTRL, S_PUT
    } state_t;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [OFF_W-1:0] off);
        logic [SUMW-1:0] s;
        s = SUMW'(base) + SUMW'(off);
        if (s >= SUMW'(BUF_BYTES)) begin
            s = s - SUMW'(BUF_BYTES);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] inc_wrap(input logic [AW-1:0] a);
        return (a == AW'(BUF_BYTES - 1)) ? '0 : a + 1'b1;
    endfunction

    state_t      state_reg;
    logic [AW-1:0] head_reg, tail_reg, waddr_reg;
    logic [UW-1:0] used_reg;
    logic [7:0]  arr_len_reg, arr_cnt_reg, rd_off_reg;
    logic [7:0]  len_reg, cnt_reg, cnt_lim_reg, byte_reg, rssi_reg;
    logic [2:0]  sub_reg;
    logic [31:0] time_reg;
    logic        crc_reg, empty_reg;
    rx_result_t  result_reg;
    logic        out_valid_reg;

    logic          accept;
    logic [SW-1:0] pkt_size;
    logic          fits;
    logic          is_last;
    logic          put_go;

    assign s_ready  = aresetn && (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign pkt_size = SW'(PKT_OVERHEAD) + SW'(len_reg);
    assign fits     = crc_reg && ((SW'(used_reg) + pkt_size) <= capacity);
    assign is_last  = (len_reg == 8'd0) || ((9'(rd_off_reg) + 9'd1) >= 9'(len_reg));
    assign put_go   = (state_reg == S_PUT) && (!out_valid_reg || m_ready);

    assign m_result = result_reg;
    assign m_valid  = out_valid_reg;

    assign sl_we    = accept && (s_item.mode == MODE_BYTE) && (arr_cnt_reg < arr_len_reg);
    assign sl_waddr = arr_cnt_reg;
    assign sl_wdata = s_item.data_byte;
    assign sl_raddr = (state_reg == S_COPY) ? cnt_reg + 8'd1 : 8'd0;

    always_comb begin
        st_raddr = head_reg;
        case (state_reg)
            S_RLEN:  st_raddr = wrap_add(head_reg, OFF_W'(rd_off_reg) + OFF_W'(1));
            S_RBYTE: st_raddr = wrap_add(head_reg, OFF_W'(len_reg) + OFF_W'(1));
            S_RTRL:  st_raddr = wrap_add(head_reg,
                                         OFF_W'(len_reg) + OFF_W'(sub_reg) + OFF_W'(2));
            default: st_raddr = head_reg;
        endcase
    end

    always_comb begin
        st_we    = 1'b0;
        st_waddr = waddr_reg;
        st_wdata = time_reg[7:0];
        case (state_reg)
            S_CHK: begin
                st_we    = fits;
                st_waddr = tail_reg;
                st_wdata = len_reg;
            end
            S_COPY: begin
                st_we    = 1'b1;
                st_wdata = (cnt_reg < cnt_lim_reg) ? sl_rdata : 8'd0;
            end
            S_TRAIL: begin
                st_we    = 1'b1;
                st_wdata = (sub_reg == 3'd0) ? rssi_reg : time_reg[7:0];
            end
            default: st_we = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            used_reg      <= '0;
            arr_len_reg   <= '0;
            arr_cnt_reg   <= '0;
            rd_off_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (put_go) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        unique case (s_item.mode)
                            MODE_START: begin
                                arr_len_reg <= clamp_len(s_item.declared_len, eff_max);
                                arr_cnt_reg <= '0;
                            end
                            MODE_BYTE: begin
                                if (arr_cnt_reg < arr_len_reg) begin
                                    arr_cnt_reg <= arr_cnt_reg + 8'd1;
                                end
                            end
                            MODE_END: begin
                                len_reg     <= clamp_len(arr_len_reg, eff_max);
                                cnt_lim_reg <= arr_cnt_reg;
                                crc_reg     <= s_item.crc_ok;
                                rssi_reg    <= {1'b0, s_item.rssi_sample};
                                time_reg    <= s_item.timestamp;
                                arr_len_reg <= '0;
                                arr_cnt_reg <= '0;
                                state_reg   <= S_CHK;
                            end
                            MODE_READ: begin
                                empty_reg <= (used_reg == '0);
                                state_reg <= S_RLEN;
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_CHK: begin
                    if (fits) begin
                        waddr_reg <= inc_wrap(tail_reg);
                        cnt_reg   <= '0;
                        sub_reg   <= '0;
                        state_reg <= (len_reg == 8'd0) ? S_TRAIL : S_COPY;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_COPY: begin
                    waddr_reg <= inc_wrap(waddr_reg);
                    cnt_reg   <= cnt_reg + 8'd1;
                    if (cnt_reg == len_reg - 8'd1) begin
                        state_reg <= S_TRAIL;
                    end
                end
                S_TRAIL: begin
                    waddr_reg <= inc_wrap(waddr_reg);
                    sub_reg   <= sub_reg + 3'd1;
                    if (sub_reg != 3'd0) begin
                        time_reg <= time_reg >> 8;
                    end
                    if (sub_reg == 3'd4) begin
                        tail_reg  <= inc_wrap(waddr_reg);
                        used_reg  <= UW'(SW'(used_reg) + pkt_size);
                        state_reg <= S_IDLE;
                    end
                end
                S_RLEN: begin
                    len_reg   <= st_rdata;
                    state_reg <= empty_reg ? S_PUT : S_RBYTE;
                end
                S_RBYTE: begin
                    byte_reg  <= ((len_reg != 8'd0) && (rd_off_reg < len_reg)) ? st_rdata
                                                                                 : 8'd0;
                    sub_reg   <= '0;
                    state_reg <= S_RTRL;
                end
                S_RTRL: begin
                    sub_reg <= sub_reg + 3'd1;
                    if (sub_reg == 3'd0) begin
                        rssi_reg <= st_rdata;
                    end else begin
                        time_reg <= {st_rdata, time_reg[31:8]};
                    end
                    if (sub_reg == 3'd4) begin
                        state_reg <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (put_go) begin
                        state_reg <= S_IDLE;
                        if (empty_reg) begin
                            result_reg <= '{1'b1, 8'd0, 8'd0, 8'sd0, 32'd0, 1'b0};
                        end else begin
                            result_reg <= '{1'b0, byte_reg, len_reg, 8'd0 - rssi_reg,
                                            time_reg, is_last};
                            if (is_last) begin
                                head_reg   <= wrap_add(head_reg,
                                                       OFF_W'(len_reg) + OFF_W'(PKT_OVERHEAD));
                                used_reg   <= (SW'(used_reg) >= pkt_size)
                                              ? UW'(SW'(used_reg) - pkt_size) : '0;
                                rd_off_reg <= '0;
                            end else begin
                                rd_off_reg <= rd_off_reg + 8'd1;
                            end
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/radio_rx_packet_queue.sv]
// Receive packet queue: start and payload byte beats are accepted every cycle while
// the queue is idle; an end beat holds the input through the length check, payload copy
// and five trailer writes on the single store write port (only the check when rejected);
// a read beat holds the input through 7 dependent store reads on the one read port (the
// length read only when empty) until its result is registered, longer while the previous result waits.
// aresetn is synchronous: pointers, counts and config defaults, no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module radio_rx_packet_queue #(
    parameter int BUF_BYTES = rrpq_pkg::BUF_BYTES_DEF,
    localparam int AW = $clog2(BUF_BYTES),
    localparam int UW = $clog2(BUF_BYTES + 1),
    localparam int SW = UW + 9
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // declared_len[7:0], data_byte[15:8], crc_ok[16], rssi_sample[23:17], timestamp[55:24]
    input  logic [rrpq_pkg::TDATA_W-1:0]  s_tdata,
    // mode[1:0]
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // payload_byte[7:0], packet_len[15:8], rssi_dbm[23:16], rx_time[55:24]
    output logic [rrpq_pkg::TDATA_W-1:0]  m_tdata,
    // queue_empty[0]
    output logic                          m_tuser,
    output logic                          m_tlast,
    input  logic                          cfg_we,
    input  rrpq_pkg::cfg_idx_t            cfg_index,
    input  logic [7:0]                    cfg_wdata
);

    import rrpq_pkg::*;

    logic [7:0]    max_payload_reg, queue_slots_reg;
    logic [SW-1:0] cap_reg;
    logic [7:0]    eff_max;
    logic [16:0]   prod;

    rx_item_t   s_item;
    rx_result_t m_result;
    logic       s_accept;

    logic          st_we;
    logic [AW-1:0] st_waddr, st_raddr;
    logic [7:0]    st_wdata, st_rdata;
    logic          sl_we;
    logic [7:0]    sl_waddr, sl_wdata, sl_raddr, sl_rdata;

    assign eff_max = clamp_len(max_payload_reg, PAYLOAD_LIMIT);
    assign prod    = 17'(queue_slots_reg) * 17'(9'(eff_max) + 9'(PKT_OVERHEAD));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= DEF_MAX_PAYLOAD;
            queue_slots_reg <= DEF_QUEUE_SLOTS;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MAX_PAYLOAD: max_payload_reg <= cfg_wdata;
                CFG_QUEUE_SLOTS: queue_slots_reg <= cfg_wdata;
                default:         max_payload_reg <= max_payload_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        cap_reg <= (prod > 17'(BUF_BYTES)) ? SW'(BUF_BYTES) : SW'(prod);
    end

    assign s_item.mode         = mode_t'(s_tuser);
    assign s_item.declared_len = s_tdata[7:0];
    assign s_item.data_byte    = s_tdata[15:8];
    assign s_item.crc_ok       = s_tdata[16];
    assign s_item.rssi_sample  = s_tdata[23:17];
    assign s_item.timestamp    = s_tdata[55:24];

    assign m_tdata = {m_result.rx_time, m_result.rssi_dbm, m_result.packet_len,
                      m_result.payload_byte};
    assign m_tuser = m_result.queue_empty;
    assign m_tlast = m_result.last_byte;

    assign s_accept = s_tvalid && s_tready;

    rrpq_ctrl #(
        .BUF_BYTES (BUF_BYTES)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_item   (s_item),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .eff_max  (eff_max),
        .capacity (cap_reg),
        .m_result (m_result),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .st_we    (st_we),
        .st_waddr (st_waddr),
        .st_wdata (st_wdata),
        .st_raddr (st_raddr),
        .st_rdata (st_rdata),
        .sl_we    (sl_we),
        .sl_waddr (sl_waddr),
        .sl_wdata (sl_wdata),
        .sl_raddr (sl_raddr),
        .sl_rdata (sl_rdata)
    );

    rrpq_ram #(
        .DEPTH (BUF_BYTES),
        .WIDTH (8)
    ) u_store (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    rrpq_ram #(
        .DEPTH (SLOT_DEPTH),
        .WIDTH (8)
    ) u_slot (
        .aclk  (aclk),
        .we    (sl_we),
        .waddr (sl_waddr),
        .wdata (sl_wdata),
        .raddr (sl_raddr),
        .rdata (sl_rdata)
    );

    `RRPQ_ASSERT_NEXT(a_no_result_from_rx, aclk, aresetn,
        s_accept && (s_item.mode != MODE_READ) && !m_tvalid, !m_tvalid)
    `RRPQ_ASSERT_NEXT(a_busy_after_end_or_read, aclk, aresetn,
        s_accept && ((s_item.mode == MODE_END) || (s_item.mode == MODE_READ)), !s_tready)
    `RRPQ_ASSERT_SAME(a_empty_queue_zero, aclk, aresetn,
        m_tvalid && m_tuser, (m_tdata == '0) && !m_tlast)
    `RRPQ_ASSERT_SAME(a_empty_packet_pops, aclk, aresetn,
        m_tvalid && !m_tuser && (m_tdata[15:8] == 8'd0), m_tlast)

endmodule
